@@ hdl/duration_string_to_seconds_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the duration string parser checker
// ---------------------------------------------------------------------------
`ifndef DURATION_STRING_TO_SECONDS_CORE_ASSERT_SVH
`define DURATION_STRING_TO_SECONDS_CORE_ASSERT_SVH

// Check on every rising edge outside reset.
`define DSTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define DSTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/dsts_pkg.sv @@
// ---------------------------------------------------------------------------
// dsts_pkg
// Shared types, constants and helper functions of the duration parser.
// ---------------------------------------------------------------------------
package dsts_pkg;

    localparam int NUMBER_BITS = 32;
    localparam int UNIT_BITS   = 25;
    localparam int SUM_BITS    = 63;
    localparam int PROD_BITS   = NUMBER_BITS + UNIT_BITS;
    localparam int WIDE_BITS   = (PROD_BITS > SUM_BITS + 1) ? PROD_BITS : SUM_BITS + 1;

    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [UNIT_BITS-1:0] SEC_ONE    = UNIT_BITS'(1);
    localparam logic [UNIT_BITS-1:0] SEC_MINUTE = UNIT_BITS'(60);
    localparam logic [UNIT_BITS-1:0] SEC_HOUR   = UNIT_BITS'(60 * 60);
    localparam logic [UNIT_BITS-1:0] SEC_DAY    = UNIT_BITS'(24 * 60 * 60);
    localparam logic [UNIT_BITS-1:0] SEC_WEEK   = UNIT_BITS'(7 * 24 * 60 * 60);
    localparam logic [UNIT_BITS-1:0] SEC_MONTH  = UNIT_BITS'(30 * 24 * 60 * 60);
    localparam logic [UNIT_BITS-1:0] SEC_YEAR   = UNIT_BITS'(365 * 24 * 60 * 60);

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_LOW_W = 8'h77;
    localparam logic [7:0] CH_LOW_D = 8'h64;
    localparam logic [7:0] CH_LOW_H = 8'h68;
    localparam logic [7:0] CH_LOW_M = 8'h6D;
    localparam logic [7:0] CH_LOW_S = 8'h73;

    typedef enum logic [2:0] {
        UNIT_SEC,
        UNIT_MIN,
        UNIT_HOUR,
        UNIT_DAY,
        UNIT_WEEK,
        UNIT_MONTH,
        UNIT_YEAR
    } unit_t;

    // One queued operation: an optional unit product to add, end of string and error.
    typedef struct packed {
        logic                   do_add;
        unit_t                  unit;
        logic [NUMBER_BITS-1:0] number;
        logic                   last;
        logic                   failed;
    } dsts_op_t;

    // Decimal accumulate, saturating at all ones.
    function automatic logic [NUMBER_BITS-1:0] acc_digit(
        input logic [NUMBER_BITS-1:0] value,
        input logic [3:0]             digit
    );
        logic [NUMBER_BITS+3:0] t;
        t = ({4'b0, value} << 3) + ({4'b0, value} << 1) + (NUMBER_BITS + 4)'(digit);
        if (t[NUMBER_BITS+3:NUMBER_BITS] != 4'b0)
            return '1;
        return t[NUMBER_BITS-1:0];
    endfunction

    function automatic logic [UNIT_BITS-1:0] unit_seconds(input unit_t unit);
        logic [UNIT_BITS-1:0] s;
        unique case (unit)
            UNIT_SEC:   s = SEC_ONE;
            UNIT_MIN:   s = SEC_MINUTE;
            UNIT_HOUR:  s = SEC_HOUR;
            UNIT_DAY:   s = SEC_DAY;
            UNIT_WEEK:  s = SEC_WEEK;
            UNIT_MONTH: s = SEC_MONTH;
            UNIT_YEAR:  s = SEC_YEAR;
            default:    s = SEC_ONE;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/duration_string_to_seconds_core.sv @@
// ---------------------------------------------------------------------------
// duration_string_to_seconds_core
// Streaming parser of duration strings into a saturating count of seconds.
// ---------------------------------------------------------------------------
// Feed the string one character per word on the slave side and flag its final
// character with s_tlast. A leading 'P' selects ISO form (Y, W, D, H, M, S
// units; M is 30 days until a 'T' or a W/D/H/M unit, minutes after that);
// anything else selects free form (w, d, h, m, s in either case, space ends a
// number, trailing digits count as seconds). One result word follows every
// string: the total in seconds on m_tdata, saturating at 2^63-1, and an error
// flag on m_tuser, with the total forced to zero on error. The block takes one
// character every cycle while the queue has room, with no gap between strings;
// the front classifier decodes each character combinationally and hands number
// and unit operations to the back end through a four-entry queue. The back end
// registers the unit product, then adds it into the running sum, one operation
// per cycle unless a held result word blocks the end of a string; the result
// register takes the total as the last operation leaves the product register.
// The input stalls only when the queue fills behind a held result word.
// ---------------------------------------------------------------------------
module duration_string_to_seconds_core
    import dsts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] character
    input  logic        s_tlast,    // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [62:0] total_seconds, [63] zero
    output logic        m_tuser     // parse_error
);

    logic                q_full;
    logic                q_push;
    dsts_op_t            q_push_op;
    logic                q_pop;
    logic                q_not_empty;
    dsts_op_t            q_head_op;
    logic [SUM_BITS-1:0] total;

    // Classify characters and track the number and mode.
    dsts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .queue_full (q_full),
        .push       (q_push),
        .push_op    (q_push_op)
    );

    // Decouple the front from result backpressure.
    dsts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (q_push_op),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_op   (q_head_op)
    );

    // Multiply, accumulate and hold the result word.
    dsts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_not_empty),
        .op        (q_head_op),
        .op_pop    (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_total (total),
        .res_error (m_tuser)
    );

    assign m_tdata = {1'b0, total};

endmodule

@@ hdl/dsts_front.sv @@
// ---------------------------------------------------------------------------
// dsts_front
// Character classifier: tracks the number being typed and the parse mode,
// and issues an operation whenever a unit closes a number or a string ends.
// ---------------------------------------------------------------------------
module dsts_front
    import dsts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_last,
    input  logic       queue_full,
    output logic       push,
    output dsts_op_t   push_op
);

    logic                   at_first_reg, at_first_next;
    logic                   iso_reg, iso_next;
    logic                   minute_reg, minute_next;
    logic                   pending_reg, pending_next;
    logic                   frozen_reg, frozen_next;
    logic                   failed_reg, failed_next;
    logic [NUMBER_BITS-1:0] number_reg, number_next;

    logic                   accept;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [7:0]             lower;
    logic                   use_free;
    logic                   use_iso;
    logic                   add;
    unit_t                  add_unit;
    logic                   frz;
    logic [NUMBER_BITS-1:0] base;
    logic                   emit;
    dsts_op_t               op;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        at_first_next = at_first_reg;
        iso_next      = iso_reg;
        minute_next   = minute_reg;
        pending_next  = pending_reg;
        frozen_next   = frozen_reg;
        failed_next   = failed_reg;
        number_next   = number_reg;
        op            = '0;
        op.unit       = UNIT_SEC;
        emit          = 1'b0;
        add           = 1'b0;
        add_unit      = UNIT_SEC;
        use_free      = 1'b0;
        use_iso       = 1'b0;
        is_digit      = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
        digit         = 4'(in_char - CH_ZERO);
        lower         = in_char | CH_CASE;
        frz           = pending_reg && frozen_reg;
        base          = pending_reg ? number_reg : '0;

        if (at_first_reg)
        begin
            at_first_next = 1'b0;
            if (in_char == CH_P)
                iso_next = 1'b1;
            else
                use_free = 1'b1;
        end
        else if (!failed_reg)
        begin
            if (iso_reg)
                use_iso = 1'b1;
            else
                use_free = 1'b1;
        end

        if (use_free)
        begin
            if (is_digit)
            begin
                pending_next = 1'b1;
                frozen_next  = frz;
                if (!frz)
                    number_next = acc_digit(base, digit);
            end
            else if (pending_reg)
            begin
                if (in_char == CH_SPACE)
                    frozen_next = 1'b1;
                else
                begin
                    unique case (lower)
                        CH_LOW_W:
                        begin
                            add      = 1'b1;
                            add_unit = UNIT_WEEK;
                        end
                        CH_LOW_D:
                        begin
                            add      = 1'b1;
                            add_unit = UNIT_DAY;
                        end
                        CH_LOW_H:
                        begin
                            add      = 1'b1;
                            add_unit = UNIT_HOUR;
                        end
                        CH_LOW_M:
                        begin
                            add      = 1'b1;
                            add_unit = UNIT_MIN;
                        end
                        CH_LOW_S:
                        begin
                            add      = 1'b1;
                            add_unit = UNIT_SEC;
                        end
                        default: failed_next = 1'b1;
                    endcase
                end
            end
        end

        if (use_iso)
        begin
            if (is_digit)
            begin
                pending_next = 1'b1;
                number_next  = acc_digit(number_reg, digit);
            end
            else if (!pending_reg)
            begin
                if (in_char == CH_T)
                    minute_next = 1'b1;
                else
                    failed_next = 1'b1;
            end
            else
            begin
                unique case (in_char)
                    CH_Y:
                    begin
                        add      = 1'b1;
                        add_unit = UNIT_YEAR;
                    end
                    CH_W:
                    begin
                        add         = 1'b1;
                        add_unit    = UNIT_WEEK;
                        minute_next = 1'b1;
                    end
                    CH_D:
                    begin
                        add         = 1'b1;
                        add_unit    = UNIT_DAY;
                        minute_next = 1'b1;
                    end
                    CH_H:
                    begin
                        add         = 1'b1;
                        add_unit    = UNIT_HOUR;
                        minute_next = 1'b1;
                    end
                    CH_M:
                    begin
                        add         = 1'b1;
                        add_unit    = minute_reg ? UNIT_MIN : UNIT_MONTH;
                        minute_next = 1'b1;
                    end
                    CH_S:
                    begin
                        add      = 1'b1;
                        add_unit = UNIT_SEC;
                    end
                    default: failed_next = 1'b1;
                endcase
            end
        end

        // Unit consumes the pending number.
        if (add)
        begin
            emit         = 1'b1;
            op.do_add    = 1'b1;
            op.unit      = add_unit;
            op.number    = number_reg;
            pending_next = 1'b0;
            frozen_next  = 1'b0;
            number_next  = '0;
        end

        // End of string: flush trailing digits (an error in ISO form), then return to reset state.
        if (in_last)
        begin
            if (!failed_next && pending_next)
            begin
                if (iso_next)
                    failed_next = 1'b1;
                else
                begin
                    op.do_add = 1'b1;
                    op.unit   = UNIT_SEC;
                    op.number = number_next;
                end
            end
            emit          = 1'b1;
            op.last       = 1'b1;
            op.failed     = failed_next;
            at_first_next = 1'b1;
            iso_next      = 1'b0;
            minute_next   = 1'b0;
            pending_next  = 1'b0;
            frozen_next   = 1'b0;
            failed_next   = 1'b0;
            number_next   = '0;
        end
    end

    assign push    = accept && emit;
    assign push_op = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_first_reg <= 1'b1;
            iso_reg      <= 1'b0;
            minute_reg   <= 1'b0;
            pending_reg  <= 1'b0;
            frozen_reg   <= 1'b0;
            failed_reg   <= 1'b0;
            number_reg   <= '0;
        end
        else if (accept)
        begin
            at_first_reg <= at_first_next;
            iso_reg      <= iso_next;
            minute_reg   <= minute_next;
            pending_reg  <= pending_next;
            frozen_reg   <= frozen_next;
            failed_reg   <= failed_next;
            number_reg   <= number_next;
        end
    end

endmodule

@@ hdl/dsts_queue.sv @@
// ---------------------------------------------------------------------------
// dsts_queue
// Small register queue of operations between front and back.
// ---------------------------------------------------------------------------
module dsts_queue
    import dsts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  dsts_op_t push_op,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output dsts_op_t head_op
);

    dsts_op_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/dsts_back.sv @@
// ---------------------------------------------------------------------------
// dsts_back
// Multiply stage and saturating accumulator; drives the result register.
// ---------------------------------------------------------------------------
module dsts_back
    import dsts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    input  dsts_op_t            op,
    output logic                op_pop,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [SUM_BITS-1:0] res_total,
    output logic                res_error
);

    logic                m_valid_reg, m_valid_next;
    logic [SUM_BITS-1:0] m_prod_reg;
    logic                m_last_reg;
    logic                m_failed_reg;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    logic [SUM_BITS-1:0] out_total_reg;
    logic                out_error_reg;

    logic [WIDE_BITS-1:0] prod_wide;
    logic [SUM_BITS-1:0]  prod_sat;
    logic [SUM_BITS:0]    sum_wide;
    logic [SUM_BITS-1:0]  sum_sat;
    logic                 out_free;
    logic                 m_advance;
    logic                 m_load;

    assign prod_wide = WIDE_BITS'(op.number) * WIDE_BITS'(unit_seconds(op.unit));
    always_comb
    begin
        if (!op.do_add)
            prod_sat = '0;
        else if (prod_wide > WIDE_BITS'(SUM_MAX))
            prod_sat = SUM_MAX;
        else
            prod_sat = prod_wide[SUM_BITS-1:0];
    end

    assign sum_wide  = {1'b0, sum_reg} + {1'b0, m_prod_reg};
    assign sum_sat   = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

    assign out_free  = !out_valid_reg || res_ready;
    assign m_advance = m_valid_reg && (!m_last_reg || out_free);
    assign m_load    = !m_valid_reg || m_advance;
    assign op_pop    = op_valid && m_load;

    always_comb
    begin
        m_valid_next   = m_load ? op_valid : m_valid_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !res_ready;
        if (m_advance)
        begin
            if (m_last_reg)
            begin
                sum_next       = '0;
                out_valid_next = 1'b1;
            end
            else
                sum_next = sum_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            m_prod_reg   <= prod_sat;
            m_last_reg   <= op.last;
            m_failed_reg <= op.failed;
        end
        if (m_advance && m_last_reg)
        begin
            out_total_reg <= m_failed_reg ? '0 : sum_sat;
            out_error_reg <= m_failed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg   <= m_valid_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_total = out_total_reg;
    assign res_error = out_error_reg;

endmodule

@@ hdl/dsts_checker.sv @@
// ---------------------------------------------------------------------------
// dsts_checker
// Port-level checks of the duration parser's result channel.
// ---------------------------------------------------------------------------
`include "duration_string_to_seconds_core_assert.svh"

module dsts_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // Hold a stalled result word.
    `DSTS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // Drop the total on a malformed string.
    `DSTS_ASSERT(a_err_zero, m_tvalid && m_tuser |-> m_tdata == 64'd0, "error result carries a nonzero total")

    // Keep the sum within the saturation limit.
    `DSTS_ASSERT(a_sat_top, m_tvalid |-> !m_tdata[63], "total exceeds 2^63-1")

    // No result word once reset has been seen at an edge.
    `DSTS_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !m_tvalid, "result valid during reset")

endmodule

bind duration_string_to_seconds_core dsts_checker u_chk (.*);
